// ----- rtl/core/text_terminal_char_writer_macros.svh -----
// Assertion macros for the text terminal character writer.
// Used by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef TEXT_TERMINAL_CHAR_WRITER_MACROS_SVH
`define TEXT_TERMINAL_CHAR_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ttcw_pkg.sv -----
// Package for the text terminal character writer.
// Holds the item types, request and character codes and default geometry; no dependencies.
`default_nettype none

package ttcw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam int MAX_ADDR_W = 13;
  localparam int POS_W      = 11;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_PLACE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_PROMPT = 8'h24;
  localparam logic [7:0] CHAR_TOP    = 8'h7F;

  localparam logic [7:0]  COLOR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET  = 16'h0720;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] pos_column;
    logic [4:0] pos_row;
  } ttcw_in_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic [15:0]      read_data;
  } ttcw_out_t;

  typedef struct packed {
    logic                  we;
    logic [MAX_ADDR_W-1:0] waddr;
    logic [15:0]           wdata;
    logic [MAX_ADDR_W-1:0] raddr;
  } ttcw_mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/text_terminal_char_writer.sv -----
// Text terminal character writer: screen sequencer, cursor, configuration and result register.
// Depends on ttcw_pkg, ttcw_screen_ram and text_terminal_char_writer_macros.svh.
//
// Usage:
// - Requests enter on in_valid/in_ready/in_data. One request is worked on at a time,
//   and in_ready is high only while the sequencer is idle.
// - Each request yields one item on out_valid/out_ready/out_data with the cursor
//   position after the request and, for a read, the cell value.
// - text_color is to be written through cfg_we/cfg_wdata while the block is idle; the block
//   itself does not enforce it.
// - An accepted request passes a dispatch step, then a done step that registers out_valid;
//   a read adds a read-wait step, a printable character a wrap step, a line feed a prompt
//   step and a tab a run of tab steps then a wrap step. in_ready rises with out_valid.
// - A scroll moves the screen up through the single memory port pair, reading then writing
//   each cell, then blanks the bottom row one cell a cycle. Clear writes each cell in turn.
// - After reset every screen cell is filled with a grey space, one cell a cycle; in_ready
//   stays low meanwhile.
// - The result register lets the next request be accepted while a result waits.
//   If the receiver stalls, a finished request holds in its last step until the
//   result register is free.
`default_nettype none

module text_terminal_char_writer
  import ttcw_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ttcw_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ttcw_out_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  `include "text_terminal_char_writer_macros.svh"

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;

  localparam logic [AW-1:0]    COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0]    SCROLL_LAST = AW'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [AW-1:0]    BLANK_FIRST = AW'(COLUMNS * (ROWS - 1));
  localparam logic [AW-1:0]    CELL_LAST   = AW'(CELLS - 1);
  localparam logic [COL_W-1:0] COLS_C      = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0] TAB_C       = COL_W'(TAB_STOP);
  localparam logic [COL_W-1:0] PROMPT_COL  = COL_W'(2);
  localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_TAB      = 4'd3;
  localparam logic [3:0] S_RDWAIT   = 4'd4;
  localparam logic [3:0] S_CLEAR    = 4'd5;
  localparam logic [3:0] S_SCR_RD   = 4'd6;
  localparam logic [3:0] S_SCR_WR   = 4'd7;
  localparam logic [3:0] S_BLANK    = 4'd8;
  localparam logic [3:0] S_PROMPT   = 4'd9;
  localparam logic [3:0] S_WRAP     = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] line_r, line_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [COL_W-1:0] tmp_r, tmp_nxt;
  logic             after_lf_r, after_lf_nxt;
  ttcw_in_t         req_r, req_nxt;
  logic [15:0]      rd_data_r, rd_data_nxt;
  logic [7:0]       text_color_r, text_color_nxt;
  logic             out_valid_r, out_valid_nxt;
  ttcw_out_t        out_data_r, out_data_nxt;

  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    pos_addr;
  logic [31:0]      cur_wide;
  logic             in_range;
  logic             in_fire;
  logic [15:0]      mem_rdata;
  ttcw_mem_req_t    mem_req;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_addr = AW'(line_r) * COLS_A + AW'(col_r);
  assign pos_addr = AW'(req_r.pos_row) * COLS_A + AW'(req_r.pos_column);
  assign cur_wide = 32'(cur_addr);
  assign in_range = (32'(req_r.pos_column) < COLUMNS) && (32'(req_r.pos_row) < ROWS);

  ttcw_screen_ram #(
    .DEPTH(CELLS)
  ) u_screen_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata_r (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    cnt_nxt        = cnt_r;
    tmp_nxt        = tmp_r;
    after_lf_nxt   = after_lf_r;
    req_nxt        = req_r;
    rd_data_nxt    = rd_data_r;
    text_color_nxt = cfg_we ? cfg_wdata : text_color_r;
    out_valid_nxt  = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    mem_req        = '0;

    case (state_r)
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MAX_ADDR_W'(cnt_r);
        mem_req.wdata = CELL_RESET;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt     = in_data;
          rd_data_nxt = '0;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        case (req_r.req_type)
          REQ_PUT: begin
            case (req_r.char_code)
              CHAR_BS: begin
                if (col_r != '0) begin
                  col_nxt = col_r - 1'b1;
                end
              end
              CHAR_TAB: begin
                tmp_nxt   = col_r;
                state_nxt = S_TAB;
              end
              CHAR_CR: begin
                col_nxt = '0;
              end
              CHAR_LF: begin
                col_nxt = '0;
                if (line_r == LAST_ROW) begin
                  after_lf_nxt = 1'b1;
                  cnt_nxt      = '0;
                  state_nxt    = S_SCR_RD;
                end else begin
                  line_nxt  = line_r + 1'b1;
                  state_nxt = S_PROMPT;
                end
              end
              default: begin
                if (req_r.char_code inside {[CHAR_SPACE:CHAR_TOP]}) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = MAX_ADDR_W'(cur_addr);
                  mem_req.wdata = {text_color_r, req_r.char_code};
                  col_nxt       = col_r + 1'b1;
                  state_nxt     = S_WRAP;
                end
              end
            endcase
          end
          REQ_PLACE: begin
            if (in_range) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = MAX_ADDR_W'(pos_addr);
              mem_req.wdata = {req_r.cell_color, req_r.char_code};
            end
          end
          REQ_READ: begin
            if (in_range) begin
              mem_req.raddr = MAX_ADDR_W'(pos_addr);
              state_nxt     = S_RDWAIT;
            end
          end
          default: begin
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        endcase
      end
      S_TAB: begin
        if (tmp_r >= TAB_C) begin
          tmp_nxt = tmp_r - TAB_C;
        end else begin
          col_nxt   = col_r + TAB_C - tmp_r;
          state_nxt = S_WRAP;
        end
      end
      S_RDWAIT: begin
        rd_data_nxt = mem_rdata;
        state_nxt   = S_DONE;
      end
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MAX_ADDR_W'(cnt_r);
        mem_req.wdata = {text_color_r, CHAR_SPACE};
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_SCR_RD: begin
        mem_req.raddr = MAX_ADDR_W'(cnt_r + COLS_A);
        state_nxt     = S_SCR_WR;
      end
      S_SCR_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MAX_ADDR_W'(cnt_r);
        mem_req.wdata = mem_rdata;
        if (cnt_r == SCROLL_LAST) begin
          cnt_nxt   = BLANK_FIRST;
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SCR_RD;
        end
      end
      S_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MAX_ADDR_W'(cnt_r);
        mem_req.wdata = {text_color_r, CHAR_SPACE};
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt      = '0;
          after_lf_nxt = 1'b0;
          state_nxt    = after_lf_r ? S_PROMPT : S_DONE;
        end
      end
      S_PROMPT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MAX_ADDR_W'(cur_addr);
        mem_req.wdata = {text_color_r, CHAR_PROMPT};
        col_nxt       = PROMPT_COL;
        state_nxt     = S_DONE;
      end
      S_WRAP: begin
        state_nxt = S_DONE;
        if (col_r >= COLS_C) begin
          col_nxt = '0;
          if (line_r == LAST_ROW) begin
            after_lf_nxt = 1'b0;
            cnt_nxt      = '0;
            state_nxt    = S_SCR_RD;
          end else begin
            line_nxt = line_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_position = cur_wide[POS_W-1:0];
          out_data_nxt.read_data       = rd_data_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      col_r        <= '0;
      line_r       <= '0;
      cnt_r        <= '0;
      after_lf_r   <= 1'b0;
      text_color_r <= COLOR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      cnt_r        <= cnt_nxt;
      after_lf_r   <= after_lf_nxt;
      text_color_r <= text_color_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r      <= tmp_nxt;
    req_r      <= req_nxt;
    rd_data_r  <= rd_data_nxt;
    out_data_r <= out_data_nxt;
  end

  `TTCW_ASSERT_NOW(a_col_in_screen, state_r == S_IDLE, col_r < COLS_C, "cursor column off screen while idle")
  `TTCW_ASSERT_NOW(a_line_in_screen, 1'b1, line_r <= LAST_ROW, "cursor line beyond last row")
  `TTCW_ASSERT_NEXT(a_accept_dispatch, in_fire, state_r == S_DISPATCH, "accepted item not dispatched")
  `TTCW_ASSERT_NOW(a_write_in_range, mem_req.we, mem_req.waddr <= MAX_ADDR_W'(CELL_LAST), "cell write beyond screen")

endmodule

`default_nettype wire

// ----- rtl/core/ttcw_screen_ram.sv -----
// Screen cell memory: one write port and one registered read port.
// Depends on ttcw_pkg for the memory request struct.
`default_nettype none

module ttcw_screen_ram
  import ttcw_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF
) (
  input  wire logic          clk,
  input  wire ttcw_mem_req_t mem_req,
  output logic [15:0]        rdata_r
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
    rdata_r <= mem[mem_req.raddr[AW-1:0]];
  end

endmodule

`default_nettype wire

// ----- dv/text_terminal_char_writer_test.sv -----
// Self-checking testbench for text_terminal_char_writer: screen, cursor and color are
// predicted in the testbench and each result item is compared with its prediction.
// Depends on ttcw_pkg and the text_terminal_char_writer RTL.
module text_terminal_char_writer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ttcw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int LINES = ROWS_DEF;
  localparam int TAB_W = TAB_STOP_DEF;
  localparam int CELLS = COLS * LINES;
  localparam int PHASE_ITEMS = 650;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ttcw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ttcw_out_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  ttcw_in_t pending_requests[$];
  ttcw_out_t expected_results[$];
  int requests_queued = 0;
  int requests_accepted = 0;
  int error_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit long_hold_armed = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_cycles = 0;

  logic [15:0] screen_img [CELLS];
  int cur_col;
  int cur_line;
  logic [7:0] text_color;

  text_terminal_char_writer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void scroll_up();
    if (cur_line >= LINES) begin
      cur_line = LINES - 1;
      for (int i = 0; i < COLS * (LINES - 1); i++) screen_img[i] = screen_img[i + COLS];
      for (int i = COLS * (LINES - 1); i < CELLS; i++) screen_img[i] = {text_color, CHAR_SPACE};
    end
  endfunction

  function automatic ttcw_out_t apply_request(ttcw_in_t it);
    ttcw_out_t res;
    int addr;
    bit on_screen;
    res = '0;
    on_screen = (it.pos_column < COLS) && (it.pos_row < LINES);
    addr = it.pos_row * COLS + it.pos_column;
    case (it.req_type)
      REQ_PUT: begin
        if (it.char_code == CHAR_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (it.char_code == CHAR_TAB) begin
          cur_col = (cur_col + TAB_W) - ((cur_col + TAB_W) % TAB_W);
        end else if (it.char_code == CHAR_CR) begin
          cur_col = 0;
        end else if (it.char_code == CHAR_LF) begin
          cur_line++;
          scroll_up();
          screen_img[cur_line * COLS] = {text_color, CHAR_PROMPT};
          cur_col = 2;
        end else if (it.char_code >= CHAR_SPACE && it.char_code <= CHAR_TOP) begin
          screen_img[cur_line * COLS + cur_col] = {text_color, it.char_code};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_line++;
        end
        scroll_up();
      end
      REQ_PLACE: begin
        if (on_screen) screen_img[addr] = {it.cell_color, it.char_code};
      end
      REQ_READ: begin
        if (on_screen) res.read_data = screen_img[addr];
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_img[i] = {text_color, CHAR_SPACE};
      end
    endcase
    res.cursor_position = POS_W'(cur_line * COLS + cur_col);
    return res;
  endfunction

  function automatic ttcw_in_t make_item(logic [1:0] req, logic [7:0] ch, logic [7:0] color,
                                         logic [6:0] col, logic [4:0] row);
    ttcw_in_t it;
    it.req_type = req;
    it.char_code = ch;
    it.cell_color = color;
    it.pos_column = col;
    it.pos_row = row;
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < CELLS; i++) screen_img[i] = CELL_RESET;
      cur_col = 0;
      cur_line = 0;
      text_color = COLOR_RESET;
    end else begin
      if (cfg_we) text_color = cfg_wdata;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_data));
        requests_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ttcw_out_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("Result item with no request outstanding: cursor_position %0d read_data %h",
                 out_data.cursor_position, out_data.read_data);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.cursor_position !== exp_res.cursor_position) begin
            $error("cursor_position mismatch: expected %0d, actual %0d",
                   exp_res.cursor_position, out_data.cursor_position);
            error_count++;
          end
          if (out_data.read_data !== exp_res.read_data) begin
            $error("read_data mismatch: expected %h, actual %h",
                   exp_res.read_data, out_data.read_data);
            error_count++;
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
      end else if (long_hold_armed && !long_hold_done) begin
        hold_cycles = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      out_ready <= (hold_cycles == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_item(ttcw_in_t it);
    pending_requests.push_back(it);
    requests_queued++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (requests_accepted != requests_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, logic [7:0] color, bit hold_off);
    ttcw_in_t it;
    int pick;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= color;
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    long_hold_armed <= hold_off;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      it.char_code = 8'($urandom);
      it.cell_color = 8'($urandom);
      it.pos_column = 7'(($urandom_range(9) == 0) ? $urandom_range(127, COLS)
                                                  : $urandom_range(COLS - 1));
      it.pos_row = 5'(($urandom_range(9) == 0) ? $urandom_range(31, LINES)
                                               : $urandom_range(LINES - 1));
      pick = $urandom_range(99);
      if (pick < 66) it.req_type = REQ_PUT;
      else if (pick < 80) it.req_type = REQ_PLACE;
      else if (pick < 98) it.req_type = REQ_READ;
      else it.req_type = REQ_CLEAR;
      if (it.req_type == REQ_PUT) begin
        pick = $urandom_range(99);
        if (pick < 66) it.char_code = 8'($urandom_range(CHAR_TOP, CHAR_SPACE));
        else if (pick < 72) it.char_code = CHAR_LF;
        else if (pick < 78) it.char_code = CHAR_CR;
        else if (pick < 84) it.char_code = CHAR_BS;
        else if (pick < 90) it.char_code = CHAR_TAB;
        else if (pick < 95) it.char_code = 8'($urandom_range(CHAR_SPACE - 1, 0));
        else it.char_code = 8'($urandom_range(255, CHAR_TOP + 1));
      end
      queue_item(it);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct <= 22;
    rx_idle_pct <= 50;

    queue_item(make_item(REQ_PUT, CHAR_BS, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, CHAR_SPACE, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, 8'h41, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, CHAR_TOP, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, 8'h1F, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, 8'h80, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, 8'hFF, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, 8'h00, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, CHAR_TAB, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, CHAR_BS, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, CHAR_CR, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, CHAR_LF, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PLACE, 8'hFF, 8'hFF, 7'd79, 5'd24));
    queue_item(make_item(REQ_PLACE, 8'h00, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PLACE, 8'h5A, 8'h3C, 7'd80, 5'd0));
    queue_item(make_item(REQ_PLACE, 8'h5A, 8'h3C, 7'd0, 5'd25));
    queue_item(make_item(REQ_PLACE, 8'hA5, 8'hC3, 7'd127, 5'd31));
    queue_item(make_item(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    queue_item(make_item(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_READ, 8'h00, 8'h00, 7'd127, 5'd31));
    queue_item(make_item(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd1));
    queue_item(make_item(REQ_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    queue_item(make_item(REQ_PUT, CHAR_TAB, 8'h00, 7'd0, 5'd0));
    queue_item(make_item(REQ_PUT, 8'h7E, 8'h00, 7'd0, 5'd0));
    drain();

    run_phase(22, 50, 8'hFF, 1'b0);
    run_phase(50, 22, 8'h00, 1'b0);
    run_phase(0, 0, 8'($urandom), 1'b1);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
